[rtl/bc_pkg.sv]
// shared types and constants for the barycentric weight pipeline
`timescale 1ns / 1ps
package bc_pkg;
    // weight fraction bits and derived widths
    localparam int WFB  = 16;
    localparam int NDIV = WFB + 1;
    localparam int DW   = 33;
    localparam int SW   = 68;
    localparam int LW   = 23;
    localparam int PW   = 136;
    localparam int NV   = 8 + NDIV;

    // how a clamped ratio is produced
    localparam logic [1:0] W_ZERO = 2'd0;
    localparam logic [1:0] W_ONE  = 2'd1;
    localparam logic [1:0] W_DIV  = 2'd2;

    typedef logic [DW-1:0] t_diff;

    // edge and point offsets relative to vertex a
    typedef struct packed {
        t_diff [2:0] u;
        t_diff [2:0] v;
        t_diff [2:0] p;
    } t_item;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_st;

    // one result item
    typedef struct packed {
        logic [WFB:0]        wc;
        logic [WFB:0]        wb;
        logic signed [WFB+1:0] wa;
        logic                ok;
    } t_res;
endpackage

[rtl/bc_wmul.sv]
// pipelined signed 68 x 68 multiplier built from 23-bit limb products
`timescale 1ns / 1ps
module bc_wmul (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [bc_pkg::SW-1:0]   i_a,
    input  logic signed [bc_pkg::SW-1:0]   i_b,
    output logic signed [bc_pkg::PW-1:0]   o_p
);
    logic [3*bc_pkg::LW-1:0]   r_ma, r_mb;
    logic [2:0]                r_sgn;
    logic [2*bc_pkg::LW-1:0]   r_pp [0:2][0:2];
    logic [bc_pkg::PW-1:0]     r_row [0:2];
    logic [bc_pkg::PW-1:0]     mag;
    logic [bc_pkg::SW-1:0]     abs_a, abs_b;

    // magnitudes
    assign abs_a = i_a[bc_pkg::SW-1] ? bc_pkg::SW'(-i_a) : bc_pkg::SW'(i_a);
    assign abs_b = i_b[bc_pkg::SW-1] ? bc_pkg::SW'(-i_b) : bc_pkg::SW'(i_b);

    // row sums and final sum
    assign mag = r_row[0] + (r_row[1] << bc_pkg::LW) + (r_row[2] << (2 * bc_pkg::LW));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma     <= {1'b0, abs_a};
            r_mb     <= {1'b0, abs_b};
            r_sgn[0] <= i_a[bc_pkg::SW-1] ^ i_b[bc_pkg::SW-1];
            r_sgn[2:1] <= r_sgn[1:0];
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_pp[i][j] <= r_ma[i*bc_pkg::LW +: bc_pkg::LW]
                                * r_mb[j*bc_pkg::LW +: bc_pkg::LW];
                end
            end
            for (int i = 0; i < 3; i++) begin
                r_row[i] <= bc_pkg::PW'(r_pp[i][0])
                          + (bc_pkg::PW'(r_pp[i][1]) << bc_pkg::LW)
                          + (bc_pkg::PW'(r_pp[i][2]) << (2 * bc_pkg::LW));
            end
            o_p <= r_sgn[2] ? $signed(-mag) : $signed(mag);
        end
    end
endmodule

[rtl/bc_fifo.sv]
// four-entry queue between the front and back parts
`timescale 1ns / 1ps
module bc_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bc_pkg::t_item     i_data,
    input  logic              i_pop,
    output bc_pkg::t_item     o_data,
    output bc_pkg::t_fifo_st  o_st
);
    bc_pkg::t_item r_mem [0:3];
    logic [1:0]    r_wp, r_rp;
    logic [2:0]    r_cnt;

    assign o_data     = r_mem[r_rp];
    assign o_st.full  = (r_cnt == 3'd4);
    assign o_st.empty = (r_cnt == 3'd0);

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (i_push) r_wp <= r_wp + 2'd1;
            if (i_pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(i_push) - 3'(i_pop);
        end
    end
endmodule

[rtl/bc_front.sv]
// input stage: takes a transfer and forms edge and point offsets
`timescale 1ns / 1ps
module bc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [383:0]      i_data,
    input  bc_pkg::t_fifo_st  i_st,
    output logic              o_push,
    output bc_pkg::t_item     o_item
);
    logic          r_fv;
    bc_pkg::t_item r_item, n_item;
    logic          acc;

    assign o_ready = !r_fv || !i_st.full;
    assign o_push  = r_fv && !i_st.full;
    assign o_item  = r_item;
    assign acc     = i_valid && o_ready;

    // offsets from vertex a
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_item.u[k] = {i_data[32*(3+k)+31], i_data[32*(3+k) +: 32]}
                        - {i_data[32*k+31], i_data[32*k +: 32]};
            n_item.v[k] = {i_data[32*(6+k)+31], i_data[32*(6+k) +: 32]}
                        - {i_data[32*k+31], i_data[32*k +: 32]};
            n_item.p[k] = {i_data[32*(9+k)+31], i_data[32*(9+k) +: 32]}
                        - {i_data[32*k+31], i_data[32*k +: 32]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_item <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (acc) begin
            r_fv <= 1'b1;
        end else if (o_push) begin
            r_fv <= 1'b0;
        end
    end
endmodule

[rtl/bc_back.sv]
// math pipeline: dot products, wide products, classification, division
`timescale 1ns / 1ps
module bc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bc_pkg::t_fifo_st  i_st,
    input  bc_pkg::t_item     i_item,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output bc_pkg::t_res      o_res
);
    logic                            en;
    logic [bc_pkg::NV-1:0]           r_vld;
    logic                            r_ovld;
    bc_pkg::t_res                    r_res, n_res;
    logic signed [2*bc_pkg::DW-1:0]  r_m [0:4][0:2];
    logic signed [bc_pkg::SW-1:0]    r_dot [0:4];
    logic signed [bc_pkg::PW-1:0]    w_p [0:5];
    logic signed [bc_pkg::PW-1:0]    r_d, r_na, r_nb;
    logic [bc_pkg::PW-1:0]           r_den [0:bc_pkg::NDIV];
    logic [bc_pkg::PW-1:0]           r_rb  [0:bc_pkg::NDIV];
    logic [bc_pkg::PW-1:0]           r_rc  [0:bc_pkg::NDIV];
    logic [bc_pkg::NDIV-1:0]         r_qb  [0:bc_pkg::NDIV];
    logic [bc_pkg::NDIV-1:0]         r_qc  [0:bc_pkg::NDIV];
    logic [1:0]                      r_mb  [0:bc_pkg::NDIV];
    logic [1:0]                      r_mc  [0:bc_pkg::NDIV];
    logic                            r_ok  [0:bc_pkg::NDIV];
    logic [bc_pkg::PW-1:0]           n_rb  [1:bc_pkg::NDIV];
    logic [bc_pkg::PW-1:0]           n_rc  [1:bc_pkg::NDIV];
    logic [bc_pkg::NDIV-1:0]         n_qb  [1:bc_pkg::NDIV];
    logic [bc_pkg::NDIV-1:0]         n_qc  [1:bc_pkg::NDIV];

    // whole pipe moves when the output register is empty or its result is taken
    assign en      = !r_ovld || i_ready;
    assign o_pop   = en && !i_st.empty;
    assign o_valid = r_ovld;
    assign o_res   = r_res;

    // six wide products: uu*vv, uv*uv, pu*vv, pv*uv, pv*uu, pu*uv
    bc_wmul u_m0 (.i_clk(i_clk), .i_en(en), .i_a(r_dot[0]), .i_b(r_dot[2]), .o_p(w_p[0]));
    bc_wmul u_m1 (.i_clk(i_clk), .i_en(en), .i_a(r_dot[1]), .i_b(r_dot[1]), .o_p(w_p[1]));
    bc_wmul u_m2 (.i_clk(i_clk), .i_en(en), .i_a(r_dot[3]), .i_b(r_dot[2]), .o_p(w_p[2]));
    bc_wmul u_m3 (.i_clk(i_clk), .i_en(en), .i_a(r_dot[4]), .i_b(r_dot[1]), .o_p(w_p[3]));
    bc_wmul u_m4 (.i_clk(i_clk), .i_en(en), .i_a(r_dot[4]), .i_b(r_dot[0]), .o_p(w_p[4]));
    bc_wmul u_m5 (.i_clk(i_clk), .i_en(en), .i_a(r_dot[3]), .i_b(r_dot[1]), .o_p(w_p[5]));

    // one restoring division step per stage for both ratios
    always_comb begin
        logic [bc_pkg::PW-1:0] tb, tc;
        for (int k = 1; k <= bc_pkg::NDIV; k++) begin
            tb = {r_rb[k-1][bc_pkg::PW-2:0], 1'b0};
            tc = {r_rc[k-1][bc_pkg::PW-2:0], 1'b0};
            if (tb >= r_den[k-1]) begin
                n_rb[k] = tb - r_den[k-1];
                n_qb[k] = {r_qb[k-1][bc_pkg::NDIV-2:0], 1'b1};
            end else begin
                n_rb[k] = tb;
                n_qb[k] = {r_qb[k-1][bc_pkg::NDIV-2:0], 1'b0};
            end
            if (tc >= r_den[k-1]) begin
                n_rc[k] = tc - r_den[k-1];
                n_qc[k] = {r_qc[k-1][bc_pkg::NDIV-2:0], 1'b1};
            end else begin
                n_rc[k] = tc;
                n_qc[k] = {r_qc[k-1][bc_pkg::NDIV-2:0], 1'b0};
            end
        end
    end

    // final rounding, clamping and first weight
    always_comb begin
        logic [bc_pkg::NDIV:0] rb, rc;
        logic [bc_pkg::WFB:0]  wb, wc;
        rb = {1'b0, r_qb[bc_pkg::NDIV]} + 1'b1;
        rc = {1'b0, r_qc[bc_pkg::NDIV]} + 1'b1;
        case (r_mb[bc_pkg::NDIV])
            bc_pkg::W_ZERO: wb = '0;
            bc_pkg::W_ONE:  wb = (bc_pkg::WFB+1)'(1) << bc_pkg::WFB;
            default:        wb = rb[bc_pkg::NDIV:1];
        endcase
        case (r_mc[bc_pkg::NDIV])
            bc_pkg::W_ZERO: wc = '0;
            bc_pkg::W_ONE:  wc = (bc_pkg::WFB+1)'(1) << bc_pkg::WFB;
            default:        wc = rc[bc_pkg::NDIV:1];
        endcase
        if (r_ok[bc_pkg::NDIV]) begin
            n_res.ok = 1'b1;
            n_res.wb = wb;
            n_res.wc = wc;
            n_res.wa = $signed((bc_pkg::WFB+2)'(1) << bc_pkg::WFB)
                     - $signed({1'b0, wb}) - $signed({1'b0, wc});
        end else begin
            n_res = '0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (en) begin
            // products of offsets
            for (int k = 0; k < 3; k++) begin
                r_m[0][k] <= $signed(i_item.u[k]) * $signed(i_item.u[k]);
                r_m[1][k] <= $signed(i_item.u[k]) * $signed(i_item.v[k]);
                r_m[2][k] <= $signed(i_item.v[k]) * $signed(i_item.v[k]);
                r_m[3][k] <= $signed(i_item.p[k]) * $signed(i_item.u[k]);
                r_m[4][k] <= $signed(i_item.p[k]) * $signed(i_item.v[k]);
            end
            // dot product sums
            for (int j = 0; j < 5; j++) begin
                r_dot[j] <= bc_pkg::SW'(r_m[j][0]) + bc_pkg::SW'(r_m[j][1])
                          + bc_pkg::SW'(r_m[j][2]);
            end
            // determinant and numerators
            r_d  <= w_p[0] - w_p[1];
            r_na <= w_p[2] - w_p[3];
            r_nb <= w_p[4] - w_p[5];
            // classify degenerate and saturated cases
            r_ok[0]  <= !(r_d == '0 || r_d[bc_pkg::PW-1]);
            r_den[0] <= r_d;
            r_rb[0]  <= r_na;
            r_rc[0]  <= r_nb;
            r_qb[0]  <= '0;
            r_qc[0]  <= '0;
            if (r_na[bc_pkg::PW-1] || r_na == '0) begin
                r_mb[0] <= bc_pkg::W_ZERO;
            end else if (r_na >= r_d) begin
                r_mb[0] <= bc_pkg::W_ONE;
            end else begin
                r_mb[0] <= bc_pkg::W_DIV;
            end
            if (r_nb[bc_pkg::PW-1] || r_nb == '0) begin
                r_mc[0] <= bc_pkg::W_ZERO;
            end else if (r_nb >= r_d) begin
                r_mc[0] <= bc_pkg::W_ONE;
            end else begin
                r_mc[0] <= bc_pkg::W_DIV;
            end
            // division stages
            for (int k = 1; k <= bc_pkg::NDIV; k++) begin
                r_den[k] <= r_den[k-1];
                r_rb[k]  <= n_rb[k];
                r_rc[k]  <= n_rc[k];
                r_qb[k]  <= n_qb[k];
                r_qc[k]  <= n_qc[k];
                r_mb[k]  <= r_mb[k-1];
                r_mc[k]  <= r_mc[k-1];
                r_ok[k]  <= r_ok[k-1];
            end
            r_res <= n_res;
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (en) begin
            r_vld  <= {r_vld[bc_pkg::NV-2:0], !i_st.empty};
            r_ovld <= r_vld[bc_pkg::NV-1];
        end
    end
endmodule

[rtl/barycentric_coordinates.sv]
// top level of the barycentric weight block
`timescale 1ns / 1ps
// Takes one triangle and query point per transfer and returns one result per
// item: weight a in signed Q2.16 and weights b and c in unsigned Q1.16 on tdata
// and the ok flag on tuser. One item can be accepted in every cycle;
// throughput is one item per cycle as long as results are taken. From input
// transfer to result an item passes one input register, the four-entry queue,
// two dot-product stages, four stages of the limb-split wide multipliers, a
// subtract stage, a classify stage, seventeen division stages (one quotient
// bit each) and the output register. A stalled output holds the math
// pipeline; the queue lets the input side keep taking items until it is full.
module barycentric_coordinates (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, point_x, point_y, point_z
    input  logic [383:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // weight_a, weight_b, weight_c, zero fill
    output logic [55:0]  o_m_axis_tdata,
    // ok
    output logic         o_m_axis_tuser
);
    bc_pkg::t_fifo_st st;
    bc_pkg::t_item    f_item, q_item;
    bc_pkg::t_res     res;
    logic             push, pop;

    bc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_s_axis_tvalid), .o_ready(o_s_axis_tready),
        .i_data(i_s_axis_tdata), .i_st(st),
        .o_push(push), .o_item(f_item)
    );

    bc_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_data(f_item),
        .i_pop(pop), .o_data(q_item), .o_st(st)
    );

    bc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_st(st), .i_item(q_item), .o_pop(pop),
        .o_valid(o_m_axis_tvalid), .i_ready(i_m_axis_tready), .o_res(res)
    );

    assign o_m_axis_tdata = {4'b0000, res.wc, res.wb, res.wa};
    assign o_m_axis_tuser = res.ok;

    // a degenerate result carries zero weights
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !res.ok |-> res.wa == '0 && res.wb == '0 && res.wc == '0)
        else $error("degenerate result with nonzero weights");

    // weights sum to one on a valid result
    a_sum_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && res.ok |->
            res.wa == $signed((bc_pkg::WFB+2)'(1) << bc_pkg::WFB)
                    - $signed({1'b0, res.wb}) - $signed({1'b0, res.wc}))
        else $error("weights do not sum to one");

    // clamped weights never exceed one
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> res.wb <= ((bc_pkg::WFB+1)'(1) << bc_pkg::WFB)
                         && res.wc <= ((bc_pkg::WFB+1)'(1) << bc_pkg::WFB))
        else $error("clamped weight above one");

    // the queue is never written while full nor read while empty
    a_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && st.full) && !(pop && st.empty))
        else $error("queue overrun or underrun");
endmodule

[verif/barycentric_coordinates_tb.sv]
// self-checking testbench for the barycentric weight block
`timescale 1ns / 1ps
module barycentric_coordinates_tb;
    localparam int WEIGHT_ONE   = 1 << bc_pkg::WFB;
    localparam int NUM_RANDOM   = 1730;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int ONE          = 32'h0001_0000;

    // one triangle query: a, b, c, point, each x y z
    typedef struct {
        logic signed [31:0] crd [12];
    } t_tri_query;

    // expected weights
    typedef struct {
        logic                          ok;
        logic signed [bc_pkg::WFB+1:0] wa;
        logic [bc_pkg::WFB:0]          wb;
        logic [bc_pkg::WFB:0]          wc;
    } t_weights;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, point_x, point_y, point_z
    logic [383:0] i_s_axis_tdata = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    // weight_a, weight_b, weight_c, zero fill
    logic [55:0]  o_m_axis_tdata;
    // ok
    logic         o_m_axis_tuser;

    t_tri_query pending_queries [$];
    t_weights   expected_weights [$];
    int         fail_count = 0;
    int         sent_count = 0;
    int         result_count = 0;
    int         degenerate_count = 0;
    int         cycle_count = 0;
    bit         stimulus_done = 1'b0;
    bit         in_accepted = 1'b0;
    int         send_gap = 0;
    int         take_gap = 0;

    barycentric_coordinates dut (.*);

    always #4 i_clk = ~i_clk;

    // ratio num/den clamped to 0..1, rounded to nearest with ties up
    function automatic logic [bc_pkg::WFB:0] clamp_ratio(logic signed [255:0] num,
                                                         logic signed [255:0] den);
        logic signed [255:0]    rem;
        logic [bc_pkg::WFB+1:0] quo;
        logic [bc_pkg::WFB+1:0] rnd;
        if (num <= 0) return '0;
        if (num >= den) return (bc_pkg::WFB+1)'(WEIGHT_ONE);
        rem = num;
        quo = '0;
        for (int i = 0; i <= bc_pkg::WFB; i++) begin
            rem = rem <<< 1;
            quo = quo << 1;
            if (rem >= den) begin
                rem = rem - den;
                quo[0] = 1'b1;
            end
        end
        rnd = quo + 1'b1;
        return rnd[bc_pkg::WFB+1:1];
    endfunction

    // barycentric weights by exact projection onto the triangle plane
    function automatic t_weights project_weights(t_tri_query q);
        logic signed [63:0]  eu [3], ev [3], ep [3];
        logic signed [255:0] uu, uv, vv, pu, pv, det, num_b, num_c;
        t_weights w;
        uu = 0; uv = 0; vv = 0; pu = 0; pv = 0;
        for (int k = 0; k < 3; k++) begin
            eu[k] = 64'(q.crd[3+k]) - 64'(q.crd[k]);
            ev[k] = 64'(q.crd[6+k]) - 64'(q.crd[k]);
            ep[k] = 64'(q.crd[9+k]) - 64'(q.crd[k]);
            uu += 256'(eu[k]) * 256'(eu[k]);
            uv += 256'(eu[k]) * 256'(ev[k]);
            vv += 256'(ev[k]) * 256'(ev[k]);
            pu += 256'(ep[k]) * 256'(eu[k]);
            pv += 256'(ep[k]) * 256'(ev[k]);
        end
        det = uu * vv - uv * uv;
        w = '{ok: 1'b0, wa: '0, wb: '0, wc: '0};
        if (det > 0) begin
            num_b = pu * vv - pv * uv;
            num_c = pv * uu - pu * uv;
            w.ok = 1'b1;
            w.wb = clamp_ratio(num_b, det);
            w.wc = clamp_ratio(num_c, det);
            w.wa = (bc_pkg::WFB+2)'(WEIGHT_ONE - int'(w.wb) - int'(w.wc));
        end
        return w;
    endfunction

    function automatic logic signed [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
            2: return ($urandom_range(0, 1)) ? 32'sh7fff_ffff : 32'sh8000_0000;
            default: return $signed($urandom_range(0, 40)) - 20;
        endcase
    endfunction

    function automatic t_tri_query random_query();
        t_tri_query q;
        int mode, kind;
        mode = $urandom_range(0, 9);
        mode = (mode < 6) ? 1 : (mode < 8) ? 0 : (mode < 9) ? 3 : 2;
        for (int i = 0; i < 12; i++) q.crd[i] = rand_coord(mode);
        kind = $urandom_range(0, 19);
        // degenerate shapes: coincident vertices or collinear edges
        if (kind == 0) begin
            for (int k = 0; k < 3; k++) q.crd[3+k] = q.crd[k];
        end else if (kind == 1) begin
            for (int k = 0; k < 3; k++) q.crd[6+k] = q.crd[3+k];
        end else if (kind == 2) begin
            for (int k = 0; k < 3; k++)
                q.crd[6+k] = q.crd[k] + 2 * (q.crd[3+k] - q.crd[k]);
        end else if (kind < 8) begin
            // point at a/4 + b/4 + c/2, plus a random offset of -32 to 32 on each coordinate
            for (int k = 0; k < 3; k++)
                q.crd[9+k] = (q.crd[k] >>> 2) + (q.crd[3+k] >>> 2) + (q.crd[6+k] >>> 1)
                             + $signed($urandom_range(0, 64)) - 32;
        end
        return q;
    endfunction

    function automatic t_tri_query make_query(int ax, int ay, int az, int bx, int by,
                                              int bz, int cx, int cy, int cz,
                                              int px, int py, int pz);
        t_tri_query q;
        q.crd = '{ax, ay, az, bx, by, bz, cx, cy, cz, px, py, pz};
        return q;
    endfunction

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // directed corners then random triangles
    initial begin
        t_tri_query q;
        pending_queries.push_back(make_query(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0, 0));
        pending_queries.push_back(make_query(0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE, 0, 0));
        pending_queries.push_back(make_query(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, ONE, 0));
        pending_queries.push_back(make_query(0, 0, 0, ONE, 0, 0, 0, ONE, 0,
                                             ONE / 3, ONE / 3, ONE * 5));
        pending_queries.push_back(make_query(0, 0, 0, ONE, 0, 0, 0, ONE, 0,
                                             -ONE, -ONE, 0));
        pending_queries.push_back(make_query(0, 0, 0, ONE, 0, 0, 0, ONE, 0,
                                             5 * ONE, 5 * ONE, 0));
        pending_queries.push_back(make_query(0, 0, 0, 0, 0, 0, 0, ONE, 0, 1, 1, 1));
        pending_queries.push_back(make_query(0, 0, 0, ONE, ONE, ONE, 2 * ONE, 2 * ONE,
                                             2 * ONE, 0, 0, 0));
        pending_queries.push_back(make_query(5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5));
        pending_queries.push_back(make_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                             32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                                             32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                                             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        pending_queries.push_back(make_query(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                             32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                                             32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                                             32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        pending_queries.push_back(make_query(0, 0, 0, 3, 0, 0, 0, 3, 0, 1, 1, 0));
        pending_queries.push_back(make_query(0, 0, 0, 1, 0, 0, 0, 1, 0, -1, -1, -1));
        pending_queries.push_back(make_query(0, 0, 0, 0, 0, ONE, ONE, 0, 0,
                                             ONE / 2, 7, ONE / 2));
        for (int i = 0; i < NUM_RANDOM; i++) begin
            q = random_query();
            pending_queries.push_back(q);
        end
    end

    // input transfer seen at the last rising edge
    always @(posedge i_clk) begin
        in_accepted <= i_s_axis_tvalid && o_s_axis_tready;
    end

    // input driver, changes on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && !in_accepted)) begin
            // hold the current transfer
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            i_s_axis_tvalid <= 1'b0;
        end else if (pending_queries.size() > 0) begin
            t_tri_query   q;
            logic [383:0] flat;
            q = pending_queries.pop_front();
            for (int i = 0; i < 12; i++) flat[32*i +: 32] = q.crd[i];
            i_s_axis_tdata <= flat;
            i_s_axis_tvalid <= 1'b1;
            send_gap <= idle_length();
        end else begin
            i_s_axis_tvalid <= 1'b0;
        end
        // output back-pressure
        if (take_gap > 0) begin
            take_gap <= take_gap - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            take_gap <= ($urandom_range(0, 3) == 0) ? idle_length() : 0;
        end
    end

    // monitor: predict on input transfer, check on output transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            cycle_count <= cycle_count + 1;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                t_tri_query q;
                t_weights w;
                for (int i = 0; i < 12; i++) q.crd[i] = i_s_axis_tdata[32*i +: 32];
                w = project_weights(q);
                expected_weights.push_back(w);
                sent_count <= sent_count + 1;
                if (!w.ok) degenerate_count <= degenerate_count + 1;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                bc_pkg::t_res got;
                t_weights w;
                got = {o_m_axis_tdata[51:0], o_m_axis_tuser};
                result_count <= result_count + 1;
                if (expected_weights.size() == 0) begin
                    $error("result with no pending query");
                    fail_count <= fail_count + 1;
                end else begin
                    w = expected_weights.pop_front();
                    if (got.ok !== w.ok) begin
                        $error("ok: expected %0d actual %0d", w.ok, got.ok);
                        fail_count <= fail_count + 1;
                    end
                    if (got.wa !== w.wa) begin
                        $error("weight_a: expected %0d actual %0d", w.wa, got.wa);
                        fail_count <= fail_count + 1;
                    end
                    if (got.wb !== w.wb) begin
                        $error("weight_b: expected %0d actual %0d", w.wb, got.wb);
                        fail_count <= fail_count + 1;
                    end
                    if (got.wc !== w.wc) begin
                        $error("weight_c: expected %0d actual %0d", w.wc, got.wc);
                        fail_count <= fail_count + 1;
                    end
                    if (o_m_axis_tdata[55:52] !== 4'b0000) begin
                        $error("zero fill: expected 0 actual %0h",
                               o_m_axis_tdata[55:52]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

    // reset, end of run and timeout
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_queries.size() == 0 && !i_s_axis_tvalid
              && expected_weights.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        stimulus_done = 1'b1;
        if (expected_weights.size() != 0) begin
            $error("%0d results never arrived", expected_weights.size());
            fail_count++;
        end
        $display("sent %0d triangle queries (%0d degenerate), checked %0d results",
                 sent_count, degenerate_count, result_count);
        if (fail_count == 0) begin
            $display("barycentric_coordinates verification clean");
        end else begin
            $display("barycentric_coordinates verification failed");
        end
        $finish;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        if (!stimulus_done) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("barycentric_coordinates verification failed");
            $finish;
        end
    end
endmodule

[files.f]
rtl/bc_pkg.sv
rtl/bc_wmul.sv
rtl/bc_fifo.sv
rtl/bc_front.sv
rtl/bc_back.sv
rtl/barycentric_coordinates.sv
verif/barycentric_coordinates_tb.sv
